// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler check failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler check failed: next-cycle implication");

`endif

// ===== hdl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, codes and helpers of the round-robin task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int COUNT_W   = $clog2(MAX_TASKS + 1);
    localparam int SUM_W     = COUNT_W + 1;
    localparam int TASK_W    = 4;
    localparam int MODE_W    = 3;
    localparam int SP_W      = 32;
    localparam int ERR_W     = 2;

    // event codes
    localparam logic [MODE_W-1:0] MODE_SWITCH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SPAWN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WAKEUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WAIT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FINISH = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REAP   = 3'd5;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_NULL_STACK = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_SLOT   = 2'd2;
    localparam logic [ERR_W-1:0] ERR_NOT_WAIT   = 2'd3;

    typedef enum logic [1:0] {
        TS_FREE     = 2'd0,
        TS_RUNNING  = 2'd1,
        TS_WAITING  = 2'd2,
        TS_FINISHED = 2'd3
    } task_state_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TASK = 2'd1,
        KIND_IDLE = 2'd2
    } cur_kind_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TASK_W-1:0] task_id;
        logic [SP_W-1:0]   stack_pointer;
    } sched_in_t;

    typedef struct packed {
        logic [TASK_W-1:0] current_task;
        logic              idle_selected;
        logic [SP_W-1:0]   next_stack_pointer;
        logic              reaped_valid;
        logic [TASK_W-1:0] reaped_task;
        logic [ERR_W-1:0]  error;
    } sched_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic execute;
        logic load_out;
    } ctrl_cmd_t;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(MAX_TASKS - 1))
            return '0;
        return s + SLOT_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
        if (s == '0)
            return SLOT_W'(MAX_TASKS - 1);
        return s - SLOT_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrts_ctrl
// Event sequencer: accept, execute, deliver; owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrts_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rrts_pkg::ctrl_cmd_t    cmd
);
    import rrts_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_FIN  = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE) || ((state_reg == ST_FIN) && out_free);
        cmd.load_in  = in_valid && in_ready;
        cmd.execute  = (state_reg == ST_EXEC);
        cmd.load_out = (state_reg == ST_FIN) && out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = in_valid ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_NEXT(a_exec_to_fin, clk, rst_n, state_reg == ST_EXEC, state_reg == ST_FIN)
    `ASSERT_NEXT(a_result_posted, clk, rst_n, cmd.load_out, out_valid_reg)

endmodule

`default_nettype wire

// ===== hdl/rrts_dp.sv =====
// ----------------------------------------------------------------------------
// rrts_dp
// Scheduler state: task tables, run deque, dead stack and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrts_dp (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rrts_pkg::ctrl_cmd_t   cmd,
    input  wire rrts_pkg::sched_in_t   in_data,
    input  wire logic                  cfg_we,
    input  wire logic [31:0]           cfg_wdata,
    output rrts_pkg::sched_out_t       out_data
);
    import rrts_pkg::*;

    // latched event
    logic [MODE_W-1:0] mode_reg;
    logic [TASK_W-1:0] id_reg;
    logic [SP_W-1:0]   sp_reg;

    // architectural state
    task_state_t        states_reg [MAX_TASKS];
    task_state_t        states_next [MAX_TASKS];
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] dead_count_reg, dead_count_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    cur_kind_t          kind_reg, kind_next;
    logic [SP_W-1:0]    idle_sp_reg, idle_sp_next;

    // storage without reset
    logic [SP_W-1:0]   stacks_mem [MAX_TASKS];
    logic [SLOT_W-1:0] deque_mem  [MAX_TASKS];
    logic [SLOT_W-1:0] dead_mem   [MAX_TASKS];

    // write / read controls
    logic              stack_we;
    logic [SLOT_W-1:0] stack_waddr;
    logic [SLOT_W-1:0] stack_raddr;
    logic              deque_we;
    logic [SLOT_W-1:0] deque_waddr;
    logic [SLOT_W-1:0] deque_wdata;
    logic              dead_we;

    logic [SP_W-1:0]   stack_rd_reg;
    logic [SLOT_W-1:0] deque_rd_reg;
    logic [SLOT_W-1:0] dead_rd_reg;
    logic              use_mem_reg, use_mem_next;
    logic              bypass_reg, bypass_next;
    sched_out_t        pend_reg, pend_next;
    sched_out_t        out_reg, out_next;

    // helpers
    logic [SLOT_W-1:0] ids;
    logic              id_ok;
    logic              cur_running;
    logic              pushed;
    logic [SLOT_W-1:0] nxt;
    logic [SUM_W-1:0]  tail_sum;
    logic [SLOT_W-1:0] tail;
    logic [SLOT_W-1:0] head_dec;
    logic [COUNT_W-1:0] dead_top;
    logic              deque_full;
    logic [ERR_W-1:0]  err;
    logic              reaped_v;
    logic [SLOT_W-1:0] reaped;
    logic [SP_W-1:0]   nsp;

    assign ids         = SLOT_W'(id_reg);
    assign id_ok       = 32'(id_reg) < 32'(MAX_TASKS);
    assign cur_running = (kind_reg == KIND_TASK) && (states_reg[cur_reg] == TS_RUNNING);
    assign deque_full  = count_reg >= COUNT_W'(MAX_TASKS);
    assign head_dec    = slot_dec(head_reg);
    assign dead_top    = dead_count_reg - COUNT_W'(1);

    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(MAX_TASKS))
            tail_sum = tail_sum - SUM_W'(MAX_TASKS);
    end
    assign tail = tail_sum[SLOT_W-1:0];

    always_comb
    begin
        states_next     = states_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        dead_count_next = dead_count_reg;
        cur_next        = cur_reg;
        kind_next       = kind_reg;
        idle_sp_next    = idle_sp_reg;
        stack_we        = 1'b0;
        stack_waddr     = cur_reg;
        stack_raddr     = cur_reg;
        deque_we        = 1'b0;
        deque_waddr     = tail;
        deque_wdata     = cur_reg;
        dead_we         = 1'b0;
        pushed          = 1'b0;
        nxt             = cur_reg;
        use_mem_next    = 1'b0;
        bypass_next     = 1'b0;
        err             = ERR_OK;
        reaped_v        = 1'b0;
        reaped          = '0;
        nsp             = '0;

        case (mode_reg)
            MODE_SWITCH:
            begin
                if ((kind_reg != KIND_NONE) && (sp_reg == '0))
                begin
                    err = ERR_NULL_STACK;
                end
                else
                begin
                    if (kind_reg == KIND_TASK)
                    begin
                        stack_we = 1'b1;
                        // preempted task goes to the back
                        if ((states_reg[cur_reg] == TS_RUNNING) && !deque_full)
                        begin
                            deque_we = 1'b1;
                            pushed   = 1'b1;
                        end
                    end
                    else if (kind_reg == KIND_IDLE)
                    begin
                        idle_sp_next = sp_reg;
                    end

                    if ((count_reg != '0) || pushed)
                    begin
                        nxt          = (count_reg != '0) ? deque_rd_reg : cur_reg;
                        head_next    = slot_inc(head_reg);
                        count_next   = pushed ? count_reg : count_reg - COUNT_W'(1);
                        cur_next     = nxt;
                        kind_next    = KIND_TASK;
                        stack_raddr  = nxt;
                        use_mem_next = 1'b1;
                        // stack written this cycle is the one picked
                        bypass_next  = (kind_reg == KIND_TASK) && (nxt == cur_reg);
                    end
                    else
                    begin
                        kind_next = KIND_IDLE;
                        nsp       = (kind_reg == KIND_IDLE) ? sp_reg : idle_sp_reg;
                    end
                end
            end
            MODE_SPAWN:
            begin
                if (!id_ok || (states_reg[ids] != TS_FREE) ||
                    ((kind_reg == KIND_TASK) && (cur_reg == ids)) || deque_full)
                begin
                    err = ERR_BAD_SLOT;
                end
                else
                begin
                    stack_we         = 1'b1;
                    stack_waddr      = ids;
                    states_next[ids] = TS_RUNNING;
                    head_next        = head_dec;
                    deque_we         = 1'b1;
                    deque_waddr      = head_dec;
                    deque_wdata      = ids;
                    count_next       = count_reg + COUNT_W'(1);
                end
            end
            MODE_WAKEUP:
            begin
                if (!id_ok)
                    err = ERR_BAD_SLOT;
                else if (states_reg[ids] != TS_WAITING)
                    err = ERR_NOT_WAIT;
                else if ((kind_reg == KIND_TASK) && (cur_reg == ids))
                    states_next[ids] = TS_RUNNING;
                else if (!deque_full)
                begin
                    states_next[ids] = TS_RUNNING;
                    head_next        = head_dec;
                    deque_we         = 1'b1;
                    deque_waddr      = head_dec;
                    deque_wdata      = ids;
                    count_next       = count_reg + COUNT_W'(1);
                end
                else
                    err = ERR_BAD_SLOT;
            end
            MODE_WAIT:
            begin
                if (!cur_running)
                    err = ERR_BAD_SLOT;
                else
                    states_next[cur_reg] = TS_WAITING;
            end
            MODE_FINISH:
            begin
                if (!cur_running || (dead_count_reg >= COUNT_W'(MAX_TASKS)))
                    err = ERR_BAD_SLOT;
                else
                begin
                    dead_we              = 1'b1;
                    dead_count_next      = dead_count_reg + COUNT_W'(1);
                    states_next[cur_reg] = TS_FINISHED;
                end
            end
            MODE_REAP:
            begin
                if (dead_count_reg != '0)
                begin
                    reaped              = dead_rd_reg;
                    reaped_v            = 1'b1;
                    dead_count_next     = dead_top;
                    states_next[reaped] = TS_FREE;
                end
            end
            default:
            begin
                err = ERR_OK;
            end
        endcase

        pend_next.current_task       = (kind_next == KIND_TASK) ? TASK_W'(cur_next) : '0;
        pend_next.idle_selected      = (kind_next == KIND_IDLE);
        pend_next.next_stack_pointer = nsp;
        pend_next.reaped_valid       = reaped_v;
        pend_next.reaped_task        = TASK_W'(reaped);
        pend_next.error              = err;
    end

    // result word, picked stack merged in
    always_comb
    begin
        out_next = pend_reg;
        if (use_mem_reg)
            out_next.next_stack_pointer = bypass_reg ? sp_reg : stack_rd_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TASKS; i++)
                states_reg[i] <= TS_FREE;
            head_reg       <= '0;
            count_reg      <= '0;
            dead_count_reg <= '0;
            cur_reg        <= '0;
            kind_reg       <= KIND_NONE;
            idle_sp_reg    <= '0;
        end
        else
        begin
            if (cmd.execute)
            begin
                states_reg     <= states_next;
                head_reg       <= head_next;
                count_reg      <= count_next;
                dead_count_reg <= dead_count_next;
                cur_reg        <= cur_next;
                kind_reg       <= kind_next;
            end
            if (cfg_we)
                idle_sp_reg <= cfg_wdata;
            else if (cmd.execute)
                idle_sp_reg <= idle_sp_next;
        end
    end

    // tables and payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg     <= in_data.mode;
            id_reg       <= in_data.task_id;
            sp_reg       <= in_data.stack_pointer;
            // deque head and dead-stack top are stable until execute
            deque_rd_reg <= deque_mem[head_reg];
            dead_rd_reg  <= dead_mem[dead_top[SLOT_W-1:0]];
        end
        if (cmd.execute)
        begin
            if (stack_we)
                stacks_mem[stack_waddr] <= sp_reg;
            stack_rd_reg <= stacks_mem[stack_raddr];
            if (deque_we)
                deque_mem[deque_waddr] <= deque_wdata;
            if (dead_we)
                dead_mem[dead_count_reg[SLOT_W-1:0]] <= cur_reg;
            pend_reg    <= pend_next;
            use_mem_reg <= use_mem_next;
            bypass_reg  <= bypass_next;
        end
        if (cmd.load_out)
            out_reg <= out_next;
    end

    assign out_data = out_reg;

    `ASSERT_IMPL(a_run_count_max, clk, rst_n, 1'b1, count_reg <= COUNT_W'(MAX_TASKS))
    `ASSERT_IMPL(a_dead_count_max, clk, rst_n, 1'b1, dead_count_reg <= COUNT_W'(MAX_TASKS))

endmodule

`default_nettype wire

// ===== hdl/round_robin_task_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Round-robin task scheduler with run deque, dead stack and idle fallback.
// ----------------------------------------------------------------------------
// An accepted input transaction is executed, then its result is written to the
//   result register in finish, which raises out_valid. No new event is taken
//   during execute; the next one is accepted in finish once the result register is free.
// An untaken result holds the next event in finish, with in_ready low.
// Reset (rst_n, async): all slots free, deque and dead stack empty, nothing
//   current, idle stack pointer zero. Stack table contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_task_scheduler_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // event transactions
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire rrts_pkg::sched_in_t   in_data,
    // result transactions
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rrts_pkg::sched_out_t       out_data,
    // idle stack pointer register
    input  wire logic                  cfg_we,
    input  wire logic [31:0]           cfg_wdata
);
    import rrts_pkg::*;

    ctrl_cmd_t cmd;

    // Sequencer: idle -> execute -> finish; finish overlaps the next accept
    // when the result register is free.
    rrts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Datapath: task state table, saved stacks, run deque (front push for
    // spawn/wakeup, back push for preemption), LIFO of finished tasks.
    rrts_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
